### design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ARC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the following cycle.
`define ARC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/arc_pkg.sv
`default_nettype none
package arc_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int PARK_DEPTH = 16;
	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int PIW = (PARK_DEPTH > 1) ? $clog2(PARK_DEPTH) : 1;
	localparam int PCW = $clog2(PARK_DEPTH + 1);

	localparam logic [1:0] ACT_SEND = 2'd0;
	localparam logic [1:0] ACT_ARP = 2'd1;
	localparam logic [1:0] ACT_IPV4 = 2'd2;
	localparam logic [1:0] ACT_TICK = 2'd3;

	localparam logic [2:0] KIND_FRAME = 3'd0;
	localparam logic [2:0] KIND_REQUEST = 3'd1;
	localparam logic [2:0] KIND_REPLY = 3'd2;
	localparam logic [2:0] KIND_ACCEPT = 3'd3;
	localparam logic [2:0] KIND_DROP = 3'd4;

	localparam logic [1:0] REG_OWN_MAC = 2'd0;
	localparam logic [1:0] REG_OWN_IP = 2'd1;
	localparam logic [1:0] REG_HOLD = 2'd2;
	localparam logic [1:0] REG_LIFE = 2'd3;

	localparam logic [15:0] OPC_REQUEST = 16'd1;
	localparam logic [15:0] HOLD_RESET = 16'd5000;
	localparam logic [15:0] LIFE_RESET = 16'd30000;
	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [47:0] own_mac;
		logic [31:0] own_ip;
		logic [15:0] hold;
		logic [15:0] life;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] ip;
		logic [7:0]  handle;
		logic [47:0] mac;
		logic        reply;
		logic        v4_hit;
		logic [15:0] elapsed;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [47:0] dst_mac;
		logic [7:0]  handle;
		logic [31:0] aip;
		logic [47:0] amac;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_V4,
		ST_WALK,
		ST_SEND,
		ST_LEARN,
		ST_COUNT,
		ST_REPLY,
		ST_RELEASE,
		ST_TICK
	} state_t;

endpackage
`default_nettype wire

### design/arc_front.sv
`default_nettype none
module arc_front import arc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] next_hop_ip,
	input  wire logic [7:0]  packet_handle,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [31:0] sender_ip,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] target_ip,
	input  wire logic [47:0] frame_dst_mac,
	input  wire logic [31:0] datagram_dst_ip,
	input  wire logic [15:0] elapsed_ms,
	output logic             q_valid,
	input  wire logic        q_pop,
	output item_t            q_item
);

	item_t      fifo_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	always_comb begin
		cls.action = action;
		cls.ip = (action == ACT_ARP) ? sender_ip : next_hop_ip;
		cls.handle = packet_handle;
		cls.mac = sender_mac;
		cls.reply = (arp_opcode == OPC_REQUEST) && (target_ip == cfg.own_ip);
		cls.v4_hit = (frame_dst_mac == cfg.own_mac) || (datagram_dst_ip == cfg.own_ip);
		cls.elapsed = elapsed_ms;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

### design/arc_engine.sv
`default_nettype none
module arc_engine import arc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_valid,
	output logic       q_pop,
	input  wire item_t q_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    res
);

	localparam logic [TW-1:0] TMAX = TW'(TABLE_DEPTH - 1);
	localparam logic [PIW-1:0] PMAX = PIW'(PARK_DEPTH - 1);

	state_t state_q, state_d;
	item_t  cur_q;

	logic [TW-1:0]  tidx_q, tidx_d;
	logic [PIW-1:0] pidx_q, pidx_d;
	logic [PCW-1:0] park_cnt_q, park_cnt_d;
	logic [PCW-1:0] wr_q, wr_d;
	logic [PCW-1:0] rel_q, rel_d;
	logic           hit_found_q, hit_found_d;
	logic [TW-1:0]  hit_idx_q, hit_idx_d;
	logic           free_found_q, free_found_d;
	logic [TW-1:0]  free_idx_q, free_idx_d;
	logic [TW-1:0]  best_idx_q, best_idx_d;
	logic [15:0]    best_age_q, best_age_d;

	logic        ent_valid_q [TABLE_DEPTH];
	logic [31:0] ent_ip_q [TABLE_DEPTH];
	logic [47:0] ent_mac_q [TABLE_DEPTH];
	logic        ent_pend_q [TABLE_DEPTH];
	logic [15:0] ent_age_q [TABLE_DEPTH];
	logic [31:0] park_ip_q [PARK_DEPTH];
	logic [7:0]  park_hdl_q [PARK_DEPTH];

	result_t res_q;
	logic    out_valid_q;
	logic    out_free;

	logic [TW-1:0] rd_idx;
	logic          rd_valid;
	logic [31:0]   rd_ip;
	logic [47:0]   rd_mac;
	logic          rd_pend;
	logic [15:0]   rd_age;
	logic [31:0]   p_ip;
	logic [7:0]    p_hdl;
	logic          p_used;

	logic          emit;
	result_t       emit_res;
	logic          ent_we;
	logic [TW-1:0] slot;
	logic [47:0]   ent_wr_mac;
	logic          ent_wr_pend;
	logic          tick_we;
	logic [16:0]   age_sum;
	logic [15:0]   age_sat;
	logic          tick_exp;
	logic          park_push;
	logic          park_copy;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res = res_q;

	assign rd_idx = (state_q == ST_WALK || state_q == ST_TICK) ? tidx_q : hit_idx_q;
	assign rd_valid = ent_valid_q[rd_idx];
	assign rd_ip = ent_ip_q[rd_idx];
	assign rd_mac = ent_mac_q[rd_idx];
	assign rd_pend = ent_pend_q[rd_idx];
	assign rd_age = ent_age_q[rd_idx];
	assign p_ip = park_ip_q[pidx_q];
	assign p_hdl = park_hdl_q[pidx_q];
	assign p_used = ({{(PCW - PIW){1'b0}}, pidx_q} < park_cnt_q);

	assign slot = hit_found_q ? hit_idx_q : (free_found_q ? free_idx_q : best_idx_q);
	assign age_sum = {1'b0, rd_age} + {1'b0, cur_q.elapsed};
	assign age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];
	assign tick_exp = (age_sat > cfg.life);

	always_comb begin
		state_d = state_q;
		tidx_d = tidx_q;
		pidx_d = pidx_q;
		park_cnt_d = park_cnt_q;
		wr_d = wr_q;
		rel_d = rel_q;
		hit_found_d = hit_found_q;
		hit_idx_d = hit_idx_q;
		free_found_d = free_found_q;
		free_idx_d = free_idx_q;
		best_idx_d = best_idx_q;
		best_age_d = best_age_q;
		q_pop = 1'b0;
		emit = 1'b0;
		emit_res = '0;
		ent_we = 1'b0;
		ent_wr_mac = '0;
		ent_wr_pend = 1'b0;
		tick_we = 1'b0;
		park_push = 1'b0;
		park_copy = 1'b0;
		case (state_q)
			ST_IDLE: begin
				tidx_d = '0;
				pidx_d = '0;
				hit_found_d = 1'b0;
				free_found_d = 1'b0;
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_item.action)
						ACT_SEND: state_d = ST_WALK;
						ACT_ARP: state_d = ST_WALK;
						ACT_IPV4: state_d = ST_V4;
						default: state_d = ST_TICK;
					endcase
				end
			end
			ST_V4: begin
				if (cur_q.v4_hit) begin
					emit = 1'b1;
					emit_res.kind = KIND_ACCEPT;
					emit_res.handle = cur_q.handle;
					emit_res.last = 1'b1;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (rd_valid && rd_ip == cur_q.ip && !hit_found_q) begin
					hit_found_d = 1'b1;
					hit_idx_d = tidx_q;
				end
				if (!rd_valid && !free_found_q) begin
					free_found_d = 1'b1;
					free_idx_d = tidx_q;
				end
				if (tidx_q == '0) begin
					best_idx_d = '0;
					best_age_d = rd_age;
				end else if (rd_valid && rd_age > best_age_q) begin
					best_idx_d = tidx_q;
					best_age_d = rd_age;
				end
				tidx_d = tidx_q + 1'b1;
				if (tidx_q == TMAX) begin
					state_d = (cur_q.action == ACT_SEND) ? ST_SEND : ST_LEARN;
				end
			end
			ST_SEND: begin
				if (hit_found_q && !rd_pend) begin
					emit = 1'b1;
					emit_res.kind = KIND_FRAME;
					emit_res.dst_mac = rd_mac;
					emit_res.handle = cur_q.handle;
					emit_res.last = 1'b1;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (hit_found_q && rd_age < cfg.hold) begin
					state_d = ST_IDLE;
				end else if (park_cnt_q == PCW'(PARK_DEPTH)) begin
					emit = 1'b1;
					emit_res.kind = KIND_DROP;
					emit_res.handle = cur_q.handle;
					emit_res.last = 1'b1;
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else begin
					emit = 1'b1;
					emit_res.kind = KIND_REQUEST;
					emit_res.dst_mac = MAC_BCAST;
					emit_res.aip = cur_q.ip;
					emit_res.last = 1'b1;
					ent_wr_pend = 1'b1;
					if (out_free) begin
						ent_we = 1'b1;
						park_push = 1'b1;
						park_cnt_d = park_cnt_q + 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_LEARN: begin
				ent_we = 1'b1;
				ent_wr_mac = cur_q.mac;
				rel_d = '0;
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (p_used && p_ip == cur_q.ip) begin
					rel_d = rel_q + 1'b1;
				end
				pidx_d = pidx_q + 1'b1;
				if (pidx_q == PMAX) begin
					pidx_d = '0;
					wr_d = '0;
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (cur_q.reply) begin
					emit = 1'b1;
					emit_res.kind = KIND_REPLY;
					emit_res.dst_mac = cur_q.mac;
					emit_res.aip = cur_q.ip;
					emit_res.amac = cur_q.mac;
					emit_res.last = (rel_q == '0);
				end
				if (!cur_q.reply || out_free) begin
					state_d = (rel_q == '0) ? ST_IDLE : ST_RELEASE;
				end
			end
			ST_RELEASE: begin
				if (p_used && p_ip == cur_q.ip) begin
					emit = 1'b1;
					emit_res.kind = KIND_FRAME;
					emit_res.dst_mac = cur_q.mac;
					emit_res.handle = p_hdl;
					emit_res.last = (rel_q == PCW'(1));
					if (out_free) begin
						rel_d = rel_q - 1'b1;
					end
				end else if (p_used) begin
					park_copy = 1'b1;
					wr_d = wr_q + 1'b1;
				end
				if (!emit || out_free) begin
					pidx_d = pidx_q + 1'b1;
					if (pidx_q == PMAX) begin
						park_cnt_d = wr_d;
						state_d = ST_IDLE;
					end
				end
			end
			ST_TICK: begin
				if (rd_valid) begin
					tick_we = 1'b1;
				end
				tidx_d = tidx_q + 1'b1;
				if (tidx_q == TMAX) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			park_cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			park_cnt_q <= park_cnt_d;
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ent_we) begin
				ent_valid_q[slot] <= 1'b1;
			end
			if (tick_we && tick_exp) begin
				ent_valid_q[tidx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tidx_q <= tidx_d;
		pidx_q <= pidx_d;
		wr_q <= wr_d;
		rel_q <= rel_d;
		hit_found_q <= hit_found_d;
		hit_idx_q <= hit_idx_d;
		free_found_q <= free_found_d;
		free_idx_q <= free_idx_d;
		best_idx_q <= best_idx_d;
		best_age_q <= best_age_d;
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (emit && out_free) begin
			res_q <= emit_res;
		end
		if (ent_we) begin
			ent_ip_q[slot] <= cur_q.ip;
			ent_mac_q[slot] <= ent_wr_mac;
			ent_pend_q[slot] <= ent_wr_pend;
			ent_age_q[slot] <= '0;
		end
		if (tick_we) begin
			ent_age_q[tidx_q] <= age_sat;
		end
		if (park_push) begin
			park_ip_q[park_cnt_q[PIW-1:0]] <= cur_q.ip;
			park_hdl_q[park_cnt_q[PIW-1:0]] <= cur_q.handle;
		end
		if (park_copy) begin
			park_ip_q[wr_q[PIW-1:0]] <= p_ip;
			park_hdl_q[wr_q[PIW-1:0]] <= p_hdl;
		end
	end

endmodule
`default_nettype wire

### design/arp_resolution_cache.sv
// ARP resolution cache for one Ethernet interface.
// Input channel (in_valid/in_ready) takes one request per handshake: a send,
// a received ARP message, a received IPv4 header or a timer tick. Requests
// are classified on entry and held in a two-entry queue ahead of the engine.
// Output channel (out_valid/out_ready) gives zero or more results per request,
// in order, with last set on the final one of each request.
// Send, ARP and tick requests walk the whole address table, one entry per
// cycle. A send then loads at most one result (a frame, an ARP request or a
// drop) into the output register; a tick ages the valid entries during its
// walk. An ARP request adds a learn step, one pass over the park queue and a
// reply step, plus a second pass over the park queue when any parked datagram
// is released, one release per cycle while the receiver takes results. An
// IPv4 header goes through a single accept-or-ignore step.
// The engine handles one request at a time; the queue keeps accepting while
// the engine works.
// Reset clears the table and park queue valid state, the queue and the output
// valid flag, and loads the configuration defaults; no clearing pass is needed.
// When the receiver stalls, the current result is held in the output register
// and the engine waits; the queue fills and then in_ready drops.
`default_nettype none
module arp_resolution_cache import arc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] next_hop_ip,
	input  wire logic [7:0]  packet_handle,
	input  wire logic [15:0] arp_opcode,
	input  wire logic [31:0] sender_ip,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] target_ip,
	input  wire logic [47:0] frame_dst_mac,
	input  wire logic [31:0] datagram_dst_ip,
	input  wire logic [15:0] elapsed_ms,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_kind,
	output logic [47:0]      dst_mac,
	output logic [7:0]       out_handle,
	output logic [31:0]      arp_dst_ip,
	output logic [47:0]      arp_dst_mac,
	output logic             last
);

	cfg_t    cfg_q;
	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_mac <= '0;
			cfg_q.own_ip <= '0;
			cfg_q.hold <= HOLD_RESET;
			cfg_q.life <= LIFE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_OWN_MAC: cfg_q.own_mac <= cfg_data;
				REG_OWN_IP: cfg_q.own_ip <= cfg_data[31:0];
				REG_HOLD: cfg_q.hold <= cfg_data[15:0];
				REG_LIFE: cfg_q.life <= cfg_data[15:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	arc_front u_front (
		.clk,
		.arst_n,
		.cfg(cfg_q),
		.in_valid,
		.in_ready,
		.action,
		.next_hop_ip,
		.packet_handle,
		.arp_opcode,
		.sender_ip,
		.sender_mac,
		.target_ip,
		.frame_dst_mac,
		.datagram_dst_ip,
		.elapsed_ms,
		.q_valid,
		.q_pop,
		.q_item
	);

	arc_engine u_engine (
		.clk,
		.arst_n,
		.cfg(cfg_q),
		.q_valid,
		.q_pop,
		.q_item,
		.out_valid,
		.out_ready,
		.res
	);

	assign out_kind = res.kind;
	assign dst_mac = res.dst_mac;
	assign out_handle = res.handle;
	assign arp_dst_ip = res.aip;
	assign arp_dst_mac = res.amac;
	assign last = res.last;

endmodule
`default_nettype wire

### design/arc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module arc_checker import arc_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  out_kind,
	input wire logic [47:0] dst_mac,
	input wire logic [7:0]  out_handle,
	input wire logic [31:0] arp_dst_ip,
	input wire logic [47:0] arp_dst_mac,
	input wire logic        last
);

	`ARC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ARC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_kind) && $stable(dst_mac) && $stable(out_handle) && $stable(last), "stalled result changed")
	`ARC_ASSERT(a_kind_legal, !out_valid || out_kind == KIND_FRAME || out_kind == KIND_REQUEST || out_kind == KIND_REPLY || out_kind == KIND_ACCEPT || out_kind == KIND_DROP, "illegal result kind")
	`ARC_ASSERT(a_request_form, !(out_valid && out_kind == KIND_REQUEST) || (dst_mac == MAC_BCAST && out_handle == 8'd0 && arp_dst_mac == 48'd0 && last), "malformed ARP request")
	`ARC_ASSERT(a_frame_form, !(out_valid && (out_kind == KIND_FRAME || out_kind == KIND_ACCEPT || out_kind == KIND_DROP)) || (arp_dst_ip == 32'd0 && arp_dst_mac == 48'd0), "ARP fields set on a data result")

endmodule

bind arp_resolution_cache arc_checker u_arc_checker (.*);
`default_nettype wire
